@@ hw/rtl/sbtoi_pkg.sv @@
// shared types and constants for the swept box time-of-impact block
// used by sbtoi_ctrl, sbtoi_datapath and swept_box_time_of_impact
// no dependencies

package sbtoi_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_EPSILON = 1'b1;

    localparam logic [31:0] STEP_TIME_RESET     = 32'd1092;
    localparam logic [15:0] SPEED_EPSILON_RESET = 16'd7;

    // field widths
    localparam int AXIS_W  = 2;
    localparam int FIELD_W = 32;
    localparam int TIME_W  = 32;

    // rewound face positions and gaps
    localparam int EDGE_W = 52;

    // one quotient bit per step
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic eval;
        logic mul_first;
        logic mul_second;
        logic edge_second;
        logic gap_check;
        logic div_step;
        logic update;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic ignore;
        logic last_axis;
        logic moving;
        logic has_gap;
        logic saturate;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

@@ hw/rtl/sbtoi_ctrl.sv @@
// sequencing state machine for the swept box time-of-impact block
// depends on sbtoi_pkg (command and status structs)

module sbtoi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sbtoi_pkg::dp_stat_t stat,
    output sbtoi_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EVAL   = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_EDGE2  = 4'd4;
    localparam logic [3:0] S_GAP    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_UPDATE = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.ignore)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (!stat.moving)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.mul_first = 1'b1;
                    state_next    = S_MUL2;
                end
            end
            S_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = S_EDGE2;
            end
            S_EDGE2:
            begin
                cmd.edge_second = 1'b1;
                state_next      = S_GAP;
            end
            S_GAP:
            begin
                cmd.gap_check = 1'b1;
                if (!stat.has_gap)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.saturate)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.last_axis)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/sbtoi_datapath.sv @@
// datapath: item capture, overlap count, rewind multiplier, gap, serial divider,
// best-time tracking, configuration registers and output register
// depends on sbtoi_pkg

module sbtoi_datapath #(
    parameter int AXIS_COUNT  = 3,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_en,
    input  logic [sbtoi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sbtoi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [sbtoi_pkg::AXIS_W-1:0]        axis,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_position,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_velocity,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_extent_low,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_extent_high,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_position,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_velocity,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_extent_low,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_extent_high,
    input  sbtoi_pkg::dp_cmd_t                  cmd,
    output sbtoi_pkg::dp_stat_t                 stat,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                boxes_overlap,
    output logic                                impact_valid,
    output logic [sbtoi_pkg::TIME_W-1:0]        impact_time,
    output logic [sbtoi_pkg::AXIS_W-1:0]        normal_axis
);

    localparam int FW = sbtoi_pkg::FIELD_W;
    localparam int EW = sbtoi_pkg::EDGE_W;
    localparam int COORD_BITS = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
    localparam int SX = FW - COORD_BITS;
    localparam logic [sbtoi_pkg::AXIS_W-1:0] LAST_AXIS =
        sbtoi_pkg::AXIS_W'(AXIS_COUNT - 1);
    localparam logic [1:0] OVL_FULL = 2'(AXIS_COUNT);
    localparam logic [1:0] OVL_MAX  = 2'd3;
    localparam int TIME_WL = sbtoi_pkg::TIME_W;

    // coordinates are taken as COORD_BITS-wide two's complement values
    function automatic logic signed [FW-1:0] sx(input logic [FW-1:0] f);
        logic [FW-1:0] s;
        s = f << SX;
        return $signed(s) >>> SX;
    endfunction

    function automatic logic [FW-1:0] mag(input logic signed [FW-1:0] v);
        return v[FW-1] ? (~v + 1'b1) : v;
    endfunction

    // face one step back: x - floor(v*dt/2^16) + offset
    function automatic logic signed [EW-1:0] rewind_face(
        input logic signed [FW-1:0] x,
        input logic                 neg,
        input logic [63:0]          p,
        input logic signed [FW-1:0] h
    );
        logic [63:0]          pr;
        logic signed [EW-1:0] xe;
        logic signed [EW-1:0] re;
        logic signed [EW-1:0] he;
        pr = neg ? (p + 64'h0000_0000_0000_FFFF) : p;
        xe = EW'(x);
        he = EW'(h);
        re = $signed({{(EW-48){1'b0}}, pr[63:16]});
        return neg ? (xe + re + he) : (xe - re + he);
    endfunction

    // configuration
    logic [31:0] step_time_reg;
    logic [15:0] speed_epsilon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg     <= sbtoi_pkg::STEP_TIME_RESET;
            speed_epsilon_reg <= sbtoi_pkg::SPEED_EPSILON_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                sbtoi_pkg::REG_STEP_TIME:     step_time_reg     <= cfg_data;
                sbtoi_pkg::REG_SPEED_EPSILON: speed_epsilon_reg <= cfg_data[15:0];
                default:                      ;
            endcase
        end
    end

    // captured item
    logic [sbtoi_pkg::AXIS_W-1:0] axis_reg;
    logic signed [FW-1:0] xa_reg, va_reg, loa_reg, hia_reg;
    logic signed [FW-1:0] xb_reg, vb_reg, lob_reg, hib_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            axis_reg <= axis;
            xa_reg   <= sx(a_position);
            va_reg   <= sx(a_velocity);
            loa_reg  <= sx(a_extent_low);
            hia_reg  <= sx(a_extent_high);
            xb_reg   <= sx(b_position);
            vb_reg   <= sx(b_velocity);
            lob_reg  <= sx(b_extent_low);
            hib_reg  <= sx(b_extent_high);
        end
    end

    // overlap and relative speed
    logic signed [FW:0] a_hi_sum, a_lo_sum, b_hi_sum, b_lo_sum;
    logic               overlap_now;
    logic signed [FW:0] vrel;
    logic [FW:0]        vrel_mag;

    assign a_hi_sum    = (FW+1)'(xa_reg) + (FW+1)'(hia_reg);
    assign a_lo_sum    = (FW+1)'(xa_reg) + (FW+1)'(loa_reg);
    assign b_hi_sum    = (FW+1)'(xb_reg) + (FW+1)'(hib_reg);
    assign b_lo_sum    = (FW+1)'(xb_reg) + (FW+1)'(lob_reg);
    assign overlap_now = (a_hi_sum > b_lo_sum) && (b_hi_sum > a_lo_sum);
    assign vrel        = (FW+1)'(va_reg) - (FW+1)'(vb_reg);
    assign vrel_mag    = vrel[FW] ? (~vrel + 1'b1) : vrel;

    logic [1:0]         overlap_count_reg;
    logic [1:0]         overlap_base;
    logic [TIME_WL-1:0] best_time_reg;
    logic [sbtoi_pkg::AXIS_W-1:0] best_axis_reg;

    logic        moving_reg;
    logic        a_first_reg;
    logic [FW:0] speed_reg;

    assign overlap_base = (axis_reg == '0) ? 2'd0 : overlap_count_reg;

    // rewind products and faces
    logic signed [FW-1:0] v_first, v_second;
    logic [63:0]          prod_reg;
    logic signed [EW-1:0] edge1_reg, edge2_reg;
    logic signed [EW-1:0] gap;
    logic signed [EW-1:0] speed_scaled;

    assign v_first      = a_first_reg ? va_reg : vb_reg;
    assign v_second     = a_first_reg ? vb_reg : va_reg;
    assign gap          = edge2_reg - edge1_reg;
    assign speed_scaled = $signed({{(EW-FW-17){1'b0}}, speed_reg, 16'h0000});

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            moving_reg  <= vrel_mag > (FW+1)'(speed_epsilon_reg);
            a_first_reg <= !vrel[FW] && (vrel != '0);
            speed_reg   <= vrel_mag;
        end
        if (cmd.mul_first)
        begin
            prod_reg <= mag(v_first) * step_time_reg;
        end
        if (cmd.mul_second)
        begin
            edge1_reg <= rewind_face(a_first_reg ? xa_reg : xb_reg, v_first[FW-1],
                                     prod_reg, a_first_reg ? hia_reg : hib_reg);
            prod_reg  <= mag(v_second) * step_time_reg;
        end
        if (cmd.edge_second)
        begin
            edge2_reg <= rewind_face(a_first_reg ? xb_reg : xa_reg, v_second[FW-1],
                                     prod_reg, a_first_reg ? lob_reg : loa_reg);
        end
    end

    // restoring divider, quotient shifts in from the bottom of quot_reg
    logic [TIME_WL-1:0]              rem_reg;
    logic [TIME_WL-1:0]              quot_reg;
    logic [sbtoi_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [FW:0]                     trial;
    logic                            trial_fits;
    logic [FW:0]                     trial_diff;

    assign trial      = {rem_reg, quot_reg[TIME_WL-1]};
    assign trial_fits = trial >= speed_reg;
    assign trial_diff = trial - speed_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.gap_check && stat.has_gap)
        begin
            if (stat.saturate)
            begin
                quot_reg <= '1;
            end
            else
            begin
                rem_reg     <= gap[47:16];
                quot_reg    <= {gap[15:0], 16'h0000};
                div_cnt_reg <= sbtoi_pkg::DIV_CNT_W'(sbtoi_pkg::DIV_STEPS - 1);
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_fits ? trial_diff[TIME_WL-1:0] : trial[TIME_WL-1:0];
            quot_reg    <= {quot_reg[TIME_WL-2:0], trial_fits};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // per-pair state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlap_count_reg <= 2'd0;
            best_time_reg     <= '0;
            best_axis_reg     <= '0;
        end
        else if (cmd.eval)
        begin
            overlap_count_reg <= (overlap_now && overlap_base != OVL_MAX) ?
                                 overlap_base + 2'd1 : overlap_base;
            if (axis_reg == '0)
            begin
                best_time_reg <= '0;
                best_axis_reg <= '0;
            end
        end
        else if (cmd.update && quot_reg > best_time_reg)
        begin
            best_time_reg <= quot_reg;
            best_axis_reg <= axis_reg;
        end
    end

    // output register
    logic                       out_valid_reg;
    logic                       boxes_overlap_reg;
    logic                       impact_valid_reg;
    logic [TIME_WL-1:0]         impact_time_reg;
    logic [sbtoi_pkg::AXIS_W-1:0] normal_axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            boxes_overlap_reg <= overlap_count_reg == OVL_FULL;
            impact_valid_reg  <= best_time_reg != '0;
            impact_time_reg   <= best_time_reg;
            normal_axis_reg   <= (best_time_reg != '0) ? best_axis_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign boxes_overlap = boxes_overlap_reg;
    assign impact_valid  = impact_valid_reg;
    assign impact_time   = impact_time_reg;
    assign normal_axis   = normal_axis_reg;

    assign stat.ignore    = axis_reg > LAST_AXIS;
    assign stat.last_axis = axis_reg == LAST_AXIS;
    assign stat.moving    = moving_reg;
    assign stat.has_gap   = !gap[EW-1] && (gap != '0);
    assign stat.saturate  = gap >= speed_scaled;
    assign stat.div_last  = div_cnt_reg == '0;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

@@ hw/rtl/swept_box_time_of_impact.sv @@
// swept box time of impact, one axis per transfer; ready again once the item is done:
// a moving axis with a gap uses the multiplier twice, then a 32-step serial divider;
// saturated or gapless: no divider; slow: no multiplier or divider; out of range: nothing
// a last-axis result turns valid as ready returns, or later while the output is held
// throughput: one axis item at a time, the next transfer taken while ready is high
// reset: asynchronous active low, clears pair state and restores register defaults

module swept_box_time_of_impact #(
    parameter int AXIS_COUNT  = 3,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [sbtoi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sbtoi_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sbtoi_pkg::AXIS_W-1:0]         axis,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_position,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_velocity,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_extent_low,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] a_extent_high,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_position,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_velocity,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_extent_low,
    input  logic signed [sbtoi_pkg::FIELD_W-1:0] b_extent_high,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 boxes_overlap,
    output logic                                 impact_valid,
    output logic [sbtoi_pkg::TIME_W-1:0]         impact_time,
    output logic [sbtoi_pkg::AXIS_W-1:0]         normal_axis
);

    sbtoi_pkg::dp_cmd_t  cmd;
    sbtoi_pkg::dp_stat_t stat;

    sbtoi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbtoi_datapath #(
        .AXIS_COUNT  (AXIS_COUNT),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .axis          (axis),
        .a_position    (a_position),
        .a_velocity    (a_velocity),
        .a_extent_low  (a_extent_low),
        .a_extent_high (a_extent_high),
        .b_position    (b_position),
        .b_velocity    (b_velocity),
        .b_extent_low  (b_extent_low),
        .b_extent_high (b_extent_high),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .boxes_overlap (boxes_overlap),
        .impact_valid  (impact_valid),
        .impact_time   (impact_time),
        .normal_axis   (normal_axis)
    );

endmodule
